// ===== hw/rtl/pgr_pkg.sv =====
// shared types and constants of the push gesture recognizer
package pgr_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CONF_MIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REACH_RATIO = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PUSH_DEPTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VOTES_NEED  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ABORT_LIM   = 3'd4;

	// register reset values
	localparam logic [7:0]  RST_CONF_MIN    = 8'd128;
	localparam logic [11:0] RST_REACH_RATIO = 12'd502;
	localparam logic [11:0] RST_PUSH_DEPTH  = 12'd300;
	localparam logic [3:0]  RST_VOTES_NEED  = 4'd2;
	localparam logic [15:0] RST_ABORT_LIM   = 16'd30;

	// fixed field widths
	localparam int UID_W   = 4;
	localparam int JOINT_W = 48;
	localparam int CONF_W  = 8;
	localparam int VOTE_W  = 4;
	localparam int ABORT_W = 16;

	localparam logic [VOTE_W-1:0]  VOTE_MAX  = '1;
	localparam logic [ABORT_W-1:0] ABORT_MAX = '1;

	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_MOTION   = 2'd1,
		EV_COMPLETE = 2'd2,
		EV_ABORT    = 2'd3
	} pgr_event_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HAND,
		S_TORSO,
		S_MID,
		S_DEC
	} pgr_state_t;

endpackage

// ===== hw/rtl/push_gesture_recognizer_top.sv =====
// push gesture recognizer: per-user state in a small memory, read-modify-write per frame
//
// channel   dir  handshake          payload
// -------   ---  -----------------  ----------------------------------------------
// in        in   in_valid/in_stall  user_id, left_hand, right_hand, torso, neck,
//                                   confidences
// out       out  out_valid/out_stall user_out, event_res
// cfg       in   cfg_we             cfg_index, cfg_data (write only, no wait)
//
// one item is in flight at a time; the memory read of the user's entry starts at accept
// an idle user's item goes from accept to result through the entry read, then the hand spread,
// torso length and hand midpoint norms in turn, then the decision and write-back
// a pushing user or a user number that is zero or out of range skips the torso and midpoint norms
// reset sets state, output valid and config registers, clears the entry valid bits; an invalid entry reads as zero
// a result waiting under out_stall holds the block in its decision step
module push_gesture_recognizer_top
	import pgr_pkg::*;
#(
	parameter int MAX_USERS  = 16,
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [UID_W-1:0]      user_id,
	input  logic [JOINT_W-1:0]    left_hand,
	input  logic [JOINT_W-1:0]    right_hand,
	input  logic [JOINT_W-1:0]    torso,
	input  logic [JOINT_W-1:0]    neck,
	input  logic [4*CONF_W-1:0]   confidences,
	// output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [UID_W-1:0]      user_out,
	output logic [1:0]            event_res,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CB    = COORD_BITS;
	// user numbers above 15 cannot arrive, so the memory never needs more than 16 entries
	localparam int DEPTH = (MAX_USERS < 16) ? MAX_USERS : 16;
	localparam int AW    = $clog2(DEPTH);
	localparam logic UID_ALL = (MAX_USERS > 15);
	// widths of the squared norms and the limit
	localparam int HW  = 2*CB + 2;  // hand spread and torso length squared
	localparam int MCW = CB + 3;    // doubled midpoint offset component
	localparam int MW  = 2*CB + 4;  // doubled midpoint offset squared
	localparam int LW  = HW + 12;   // ratio times torso squared
	localparam int PW  = CB + 2;    // forward travel

	typedef struct packed {
		logic signed [CB-1:0] z;
		logic signed [CB-1:0] y;
		logic signed [CB-1:0] x;
	} vec_t;

	typedef struct packed {
		logic                 pushing;
		logic                 seen;
		logic signed [CB-1:0] start_l;
		logic signed [CB-1:0] start_r;
		logic [VOTE_W-1:0]    votes;
		logic [ABORT_W-1:0]   aborts;
	} entry_t;

	// configuration registers
	logic [7:0]         conf_min_q;
	logic [11:0]        ratio_q;
	logic [11:0]        depth_q;
	logic [VOTE_W-1:0]  votes_need_q;
	logic [ABORT_W-1:0] abort_lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_min_q   <= RST_CONF_MIN;
			ratio_q      <= RST_REACH_RATIO;
			depth_q      <= RST_PUSH_DEPTH;
			votes_need_q <= RST_VOTES_NEED;
			abort_lim_q  <= RST_ABORT_LIM;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CONF_MIN:    conf_min_q   <= cfg_data[7:0];
				REG_REACH_RATIO: ratio_q      <= cfg_data[11:0];
				REG_PUSH_DEPTH:  depth_q      <= cfg_data[11:0];
				REG_VOTES_NEED:  votes_need_q <= cfg_data[VOTE_W-1:0];
				REG_ABORT_LIM:   abort_lim_q  <= cfg_data[ABORT_W-1:0];
				default: ;
			endcase
		end
	end

	// joint unpacking; bits beyond the 48-bit field read as zero
	logic [3*CB+JOINT_W-1:0] l_ext, r_ext, t_ext, n_ext;
	assign l_ext = {{(3*CB){1'b0}}, left_hand};
	assign r_ext = {{(3*CB){1'b0}}, right_hand};
	assign t_ext = {{(3*CB){1'b0}}, torso};
	assign n_ext = {{(3*CB){1'b0}}, neck};

	// control
	pgr_state_t state_q, state_d;
	logic       in_acc;
	logic       out_load;
	logic       mem_we;
	logic       out_valid_q;

	// item registers
	logic [UID_W-1:0]    uid_q;
	logic                uid_ok_q;
	vec_t                l_q, r_q, t_q, n_q;
	logic [CONF_W-1:0]   cl_q, cr_q, ct_q, cn_q;
	entry_t              entry_q;
	logic [HW-1:0]       hand_sq_q, torso_sq_q;
	logic [MW-1:0]       mid_sq_q;
	logic [LW-1:0]       limit_q;

	// memory and its read port
	entry_t              mem [DEPTH];
	entry_t              rd_q;
	logic                rd_vld_q;
	logic [DEPTH-1:0]    vld_q;
	entry_t              rd_entry;
	entry_t              wr_entry;
	pgr_event_t          ev;

	logic uid_ok;
	assign uid_ok = (user_id != '0) && (UID_ALL || (user_id < UID_W'(MAX_USERS)));
	assign in_acc = in_valid && !in_stall;
	assign rd_entry = rd_vld_q ? rd_q : '0;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		out_load = 1'b0;
		mem_we   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) state_d = S_HAND;
			end
			S_HAND: begin
				// pushing users and foreign user numbers need no norms
				if (!uid_ok_q || rd_entry.pushing) state_d = S_DEC;
				else state_d = S_TORSO;
			end
			S_TORSO: state_d = S_MID;
			S_MID:   state_d = S_DEC;
			S_DEC: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					mem_we   = uid_ok_q;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory: registered read at accept, write-back at the decision step
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_q     <= mem[user_id[AW-1:0]];
			rd_vld_q <= vld_q[user_id[AW-1:0]];
		end
		if (mem_we) mem[uid_q[AW-1:0]] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (mem_we) begin
			vld_q[uid_q[AW-1:0]] <= 1'b1;
		end
	end

	// norm datapath: three squares and a sum per step
	logic signed [CB:0]    hdx, hdy, hdz, tdx, tdy, tdz;
	logic signed [HW-1:0]  phx, phy, phz, ptx, pty, ptz;
	logic signed [MCW-1:0] mdx, mdy, mdz;
	logic signed [MW-1:0]  pmx, pmy, pmz;

	always_comb begin
		hdx = (CB+1)'(l_q.x) - (CB+1)'(r_q.x);
		hdy = (CB+1)'(l_q.y) - (CB+1)'(r_q.y);
		hdz = (CB+1)'(l_q.z) - (CB+1)'(r_q.z);
		tdx = (CB+1)'(t_q.x) - (CB+1)'(n_q.x);
		tdy = (CB+1)'(t_q.y) - (CB+1)'(n_q.y);
		tdz = (CB+1)'(t_q.z) - (CB+1)'(n_q.z);
		mdx = MCW'(l_q.x) + MCW'(r_q.x) - (MCW'(t_q.x) <<< 1);
		mdy = MCW'(l_q.y) + MCW'(r_q.y) - (MCW'(t_q.y) <<< 1);
		mdz = MCW'(l_q.z) + MCW'(r_q.z) - (MCW'(t_q.z) <<< 1);
		phx = HW'(hdx) * HW'(hdx);
		phy = HW'(hdy) * HW'(hdy);
		phz = HW'(hdz) * HW'(hdz);
		ptx = HW'(tdx) * HW'(tdx);
		pty = HW'(tdy) * HW'(tdy);
		ptz = HW'(tdz) * HW'(tdz);
		pmx = MW'(mdx) * MW'(mdx);
		pmy = MW'(mdy) * MW'(mdy);
		pmz = MW'(mdz) * MW'(mdz);
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			uid_q    <= user_id;
			uid_ok_q <= uid_ok;
			l_q      <= l_ext[3*CB-1:0];
			r_q      <= r_ext[3*CB-1:0];
			t_q      <= t_ext[3*CB-1:0];
			n_q      <= n_ext[3*CB-1:0];
			cl_q     <= confidences[CONF_W-1:0];
			cr_q     <= confidences[2*CONF_W-1:CONF_W];
			ct_q     <= confidences[3*CONF_W-1:2*CONF_W];
			cn_q     <= confidences[4*CONF_W-1:3*CONF_W];
		end
		if (state_q == S_HAND) begin
			entry_q   <= rd_entry;
			hand_sq_q <= $unsigned(phx) + $unsigned(phy) + $unsigned(phz);
		end
		if (state_q == S_TORSO) begin
			torso_sq_q <= $unsigned(ptx) + $unsigned(pty) + $unsigned(ptz);
		end
		if (state_q == S_MID) begin
			mid_sq_q <= $unsigned(pmx) + $unsigned(pmy) + $unsigned(pmz);
			limit_q  <= LW'(ratio_q) * LW'(torso_sq_q);
		end
	end

	// decision and next entry
	logic                 conf_all, conf_hands, side, near, moved;
	logic signed [PW-1:0] off_l, off_r, lim_s;
	logic                 goal, done, quit;
	logic [VOTE_W-1:0]    votes_n;
	logic [ABORT_W-1:0]   aborts_n;

	always_comb begin
		conf_hands = (cl_q >= conf_min_q) && (cr_q >= conf_min_q);
		conf_all   = conf_hands && (ct_q >= conf_min_q) && (cn_q >= conf_min_q);
		// both hands on the same side of the torso
		side  = ((l_q.x < t_q.x) && (r_q.x < t_q.x)) || ((l_q.x > t_q.x) && (r_q.x > t_q.x));
		// midpoint is doubled, hence 64 rather than 256
		near  = (LW'({mid_sq_q, 6'd0}) < limit_q) && (LW'({hand_sq_q, 8'd0}) < limit_q);
		moved = (l_q.z < entry_q.start_l) || (r_q.z < entry_q.start_r);

		off_l = PW'(entry_q.start_l) - PW'(l_q.z);
		off_r = PW'(entry_q.start_r) - PW'(r_q.z);
		lim_s = $signed(PW'(depth_q));
		goal  = (off_l > lim_s) || (off_r > lim_s);

		votes_n  = entry_q.votes;
		aborts_n = entry_q.aborts;
		if (goal) begin
			if (entry_q.votes != VOTE_MAX) votes_n = entry_q.votes + VOTE_W'(1);
		end else begin
			votes_n = '0;
			if (entry_q.aborts != ABORT_MAX) aborts_n = entry_q.aborts + ABORT_W'(1);
		end
		// completion wins over abort
		done = (votes_n >= votes_need_q);
		quit = !done && (aborts_n >= abort_lim_q);

		wr_entry = entry_q;
		ev       = EV_NONE;
		if (!entry_q.pushing) begin
			if (conf_all && side && near) begin
				if (entry_q.seen && moved) begin
					wr_entry.pushing = 1'b1;
					wr_entry.seen    = 1'b0;
					wr_entry.votes   = '0;
					wr_entry.aborts  = '0;
				end else begin
					wr_entry.seen    = 1'b1;
					wr_entry.start_l = l_q.z;
					wr_entry.start_r = r_q.z;
				end
			end
		end else if (conf_hands) begin
			wr_entry.votes  = votes_n;
			wr_entry.aborts = aborts_n;
			if (done) begin
				ev = EV_COMPLETE;
				wr_entry.pushing = 1'b0;
			end else if (quit) begin
				ev = EV_ABORT;
				wr_entry.pushing = 1'b0;
			end else begin
				ev = EV_MOTION;
			end
		end
		if (!uid_ok_q) ev = EV_NONE;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			user_out  <= uid_ok_q ? uid_q : '0;
			event_res <= ev;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_HAND))
		else $error("accepted item did not start the entry read");

	a_result_from_dec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DEC))
		else $error("result appeared outside the decision step");

	a_write_valid_user: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (uid_ok_q && out_load))
		else $error("entry written for a foreign user or without a result");

	a_end_clears_push: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && ((ev == EV_COMPLETE) || (ev == EV_ABORT))) |-> !wr_entry.pushing)
		else $error("gesture ended but entry still marked pushing");

endmodule
